>>> rtl/core/wms_pkg.sv
// Shared types and constants for the wormhole Manhattan shortest-path block.
// Holds the controller/datapath command and status words; no dependencies.
`default_nettype none

package wms_pkg;

    localparam int TOLL_W = 10;
    localparam int COST_W = 11;
    localparam logic [COST_W-1:0] COST_MAX = 11'h7FF;

    localparam logic FUNC_ENDPOINTS = 1'b0;
    localparam logic FUNC_WORMHOLE  = 1'b1;

    typedef struct packed {
        logic accept;
        logic write_a;
        logic write_b;
        logic init;
        logic latch_first;
        logic next_pass;
        logic pass_run;
        logic res_read;
        logic res_emit;
    } wms_cmd_t;

    typedef struct packed {
        logic item_last;
        logic pass_done;
        logic found;
    } wms_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/wormhole_manhattan_shortest_path.sv
// Top level of the wormhole Manhattan shortest-path block; uses wms_pkg, wms_ctrl, wms_datapath.
// An item that is not last keeps busy high while it is written; no new word is taken until then.
// A last item keeps busy high through init, the search passes (one from the start node, then one
// per node taken off the pending set) and the readout; the done strobe rises as busy falls.
// The search time is set by the relaxation pass, which reads one node per cycle from the node store.
// Reset (rst_n, asynchronous, active low) clears the sequencer, counters and flags; the receiver cannot stall.
`default_nettype none

// A job is an endpoints word followed by wormhole words; the word marked last
// starts a label-correcting search from the start point. Node 0 is the start,
// node 1 the end, nodes 2+2i and 3+2i the two ends of wormhole i. Every pair of
// nodes is joined by its Manhattan distance, and the two ends of a wormhole are
// also joined by its toll.
//
// The search runs in passes. In each pass the current node u is compared against
// every stored node v through a three-stage pipe (read, edge cost, relax). The
// lowest node still pending when its turn in the pass comes is captured as the
// next u, so no separate search over the pending flags is needed. When no node
// is pending at the end of a pass, the distance of the end point is read out,
// saturated to the result width and presented for one cycle with done high.
//
// Wormhole words beyond MAX_WORMHOLES are dropped and reported through too_many.
module wormhole_manhattan_shortest_path
    import wms_pkg::*;
#(
    parameter int MAX_WORMHOLES = 8,
    parameter int COORD_BITS    = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    input  logic [TOLL_W-1:0]     toll,
    input  logic                  last,
    output logic                  done,
    output logic [COST_W-1:0]     min_cost,
    output logic                  too_many
);

    // Commands from the sequencer and status back from the datapath.
    wms_cmd_t  cmd;
    wms_stat_t stat;

    // The sequencer decides when a word is taken (start while not busy) and
    // steps through loading, the search passes and the result readout.
    wms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the node and distance stores, the pending flags and
    // the relaxation pipe, and registers the result for its one-cycle strobe.
    wms_datapath #(
        .MAX_WORMHOLES (MAX_WORMHOLES),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .func     (func),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by       (by),
        .toll     (toll),
        .last     (last),
        .done     (done),
        .min_cost (min_cost),
        .too_many (too_many)
    );

endmodule

`default_nettype wire

>>> rtl/core/wms_ctrl.sv
// Sequencer for the wormhole shortest-path block: load, search passes, result.
// Depends on wms_pkg for the command and status words.
`default_nettype none

module wms_ctrl
    import wms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  wms_stat_t stat,
    output wms_cmd_t  cmd,
    output logic      busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR_A  = 4'd1;
    localparam logic [3:0] S_WR_B  = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_FIRST = 4'd4;
    localparam logic [3:0] S_PASS  = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_RES1  = 4'd7;
    localparam logic [3:0] S_RES2  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_WR_A;
                end
            end
            S_WR_A:
            begin
                cmd.write_a = 1'b1;
                state_next  = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.write_b = 1'b1;
                state_next  = stat.item_last ? S_INIT : S_IDLE;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                cmd.latch_first = 1'b1;
                state_next      = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass_run = 1'b1;
                if (stat.pass_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.found)
                begin
                    cmd.next_pass = 1'b1;
                    state_next    = S_PASS;
                end
                else
                begin
                    state_next = S_RES1;
                end
            end
            S_RES1:
            begin
                cmd.res_read = 1'b1;
                state_next   = S_RES2;
            end
            S_RES2:
            begin
                cmd.res_emit = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/wms_datapath.sv
// Datapath for the wormhole shortest-path block: node store, distance store,
// pending flags and the three-stage relaxation pipe. Depends on wms_pkg.
`default_nettype none

module wms_datapath
    import wms_pkg::*;
#(
    parameter int MAX_WORMHOLES = 8,
    parameter int COORD_BITS    = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wms_cmd_t              cmd,
    output wms_stat_t             stat,
    input  logic                  func,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    input  logic [TOLL_W-1:0]     toll,
    input  logic                  last,
    output logic                  done,
    output logic [COST_W-1:0]     min_cost,
    output logic                  too_many
);

    localparam int N      = 2 * MAX_WORMHOLES + 2;
    localparam int IDXW   = $clog2(N);
    localparam int CNTW   = $clog2(N + 1);
    localparam int HCW    = $clog2(MAX_WORMHOLES + 1);
    localparam int EDGE_W = COORD_BITS + 1;
    localparam int DW     = COORD_BITS + 2;
    localparam int EW     = (EDGE_W > TOLL_W) ? EDGE_W : TOLL_W;
    localparam int SW     = (DW > COST_W) ? DW : COST_W;
    localparam int NW     = 2 * COORD_BITS + TOLL_W;
    localparam logic [DW-1:0] INF = '1;

    // Latched input word.
    logic                  it_func_reg;
    logic [COORD_BITS-1:0] it_ax_reg;
    logic [COORD_BITS-1:0] it_ay_reg;
    logic [COORD_BITS-1:0] it_bx_reg;
    logic [COORD_BITS-1:0] it_by_reg;
    logic [TOLL_W-1:0]     it_toll_reg;
    logic                  it_last_reg;

    logic [HCW-1:0]        hole_cnt_reg;
    logic                  ovf_reg;

    // Node store: {x, y, toll}; both ends of a wormhole carry its toll.
    logic [NW-1:0]         node_mem [N];
    logic [NW-1:0]         node_rd_reg;
    logic                  node_we;
    logic [IDXW-1:0]       node_wa;
    logic [NW-1:0]         node_wd;
    logic                  node_re;
    logic [IDXW-1:0]       node_ra;

    logic [DW-1:0]         best_mem [N];
    logic [DW-1:0]         best_rd_reg;
    logic                  best_we;
    logic [IDXW-1:0]       best_wa;
    logic [DW-1:0]         best_wd;
    logic                  best_re;
    logic [IDXW-1:0]       best_ra;

    logic [N-1:0]          valid_reg;
    logic [N-1:0]          pend_reg;
    logic [CNTW-1:0]       used_reg;
    logic [CNTW-1:0]       iss_reg;

    logic                  p1_vld_reg;
    logic [IDXW-1:0]       p1_idx_reg;
    logic                  p2_vld_reg;
    logic [IDXW-1:0]       p2_idx_reg;
    logic [EDGE_W-1:0]     p2_edge_reg;
    logic [DW-1:0]         p2_best_reg;
    logic [COORD_BITS-1:0] p2_x_reg;
    logic [COORD_BITS-1:0] p2_y_reg;
    logic [TOLL_W-1:0]     p2_toll_reg;

    logic [IDXW-1:0]       u_idx_reg;
    logic [COORD_BITS-1:0] u_x_reg;
    logic [COORD_BITS-1:0] u_y_reg;
    logic [TOLL_W-1:0]     u_toll_reg;
    logic [DW-1:0]         u_best_reg;

    logic                  found_reg;
    logic [IDXW-1:0]       nu_idx_reg;
    logic [COORD_BITS-1:0] nu_x_reg;
    logic [COORD_BITS-1:0] nu_y_reg;
    logic [TOLL_W-1:0]     nu_toll_reg;
    logic [DW-1:0]         nu_best_reg;

    logic                  done_reg;
    logic [COST_W-1:0]     min_cost_reg;
    logic                  too_many_reg;

    logic                  store_ok;
    logic [IDXW-1:0]       base_idx;
    logic [IDXW-1:0]       wr_a_idx;
    logic                  issue;

    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [TOLL_W-1:0]     rd_toll;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [EDGE_W-1:0]     man;
    logic                  same_hole;
    logic                  toll_lt;
    logic [EDGE_W-1:0]     edge_a;
    logic [DW-1:0]         best_a;

    logic [DW-1:0]         cand;
    logic                  upd;
    logic                  pend_fin;
    logic                  first;
    logic [COST_W-1:0]     sat_cost;

    // Load addressing.
    assign store_ok = (it_func_reg == FUNC_ENDPOINTS) ||
                      (hole_cnt_reg < HCW'(MAX_WORMHOLES));
    assign base_idx = IDXW'({hole_cnt_reg, 1'b0}) + IDXW'(2);
    assign wr_a_idx = (it_func_reg == FUNC_ENDPOINTS) ? '0 : base_idx;
    assign issue    = (iss_reg < used_reg);

    assign node_we = (cmd.write_a || cmd.write_b) && store_ok;
    assign node_wa = cmd.write_b ? (wr_a_idx + IDXW'(1)) : wr_a_idx;
    assign node_wd = cmd.write_b ? {it_bx_reg, it_by_reg, it_toll_reg}
                                 : {it_ax_reg, it_ay_reg, it_toll_reg};
    assign node_re = cmd.init || (cmd.pass_run && issue);
    assign node_ra = cmd.init ? '0 : iss_reg[IDXW-1:0];

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        if (node_re)
            node_rd_reg <= node_mem[node_ra];
    end

    assign rd_x    = node_rd_reg[NW-1 -: COORD_BITS];
    assign rd_y    = node_rd_reg[TOLL_W +: COORD_BITS];
    assign rd_toll = node_rd_reg[TOLL_W-1:0];

    // Stage A: edge cost from the current node u to the node just read.
    assign dx  = (u_x_reg > rd_x) ? (u_x_reg - rd_x) : (rd_x - u_x_reg);
    assign dy  = (u_y_reg > rd_y) ? (u_y_reg - rd_y) : (rd_y - u_y_reg);
    assign man = EDGE_W'(dx) + EDGE_W'(dy);
    assign same_hole = (u_idx_reg >= IDXW'(2)) && (p1_idx_reg >= IDXW'(2)) &&
                       (u_idx_reg[IDXW-1:1] == p1_idx_reg[IDXW-1:1]) &&
                       (u_idx_reg != p1_idx_reg);
    assign toll_lt = (EW'(u_toll_reg) < EW'(man));
    assign edge_a  = (same_hole && toll_lt) ? EDGE_W'(u_toll_reg) : man;
    assign best_a  = valid_reg[p1_idx_reg] ? best_rd_reg : INF;

    // Stage B: relax and track the lowest node left pending after this pass.
    assign cand     = u_best_reg + DW'(p2_edge_reg);
    assign upd      = p2_vld_reg && (cand < p2_best_reg);
    assign pend_fin = upd || pend_reg[p2_idx_reg];
    assign first    = p2_vld_reg && pend_fin && !found_reg;

    assign best_we = cmd.init || upd;
    assign best_wa = cmd.init ? '0 : p2_idx_reg;
    assign best_wd = cmd.init ? '0 : cand;
    assign best_re = (cmd.pass_run && issue) || cmd.res_read;
    assign best_ra = cmd.res_read ? IDXW'(1) : iss_reg[IDXW-1:0];

    always_ff @(posedge clk)
    begin
        if (best_we)
            best_mem[best_wa] <= best_wd;
        if (best_re)
            best_rd_reg <= best_mem[best_ra];
    end

    assign sat_cost = (SW'(best_rd_reg) > SW'(COST_MAX)) ? COST_MAX
                                                         : COST_W'(best_rd_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            valid_reg    <= '0;
            pend_reg     <= '0;
            used_reg     <= '0;
            iss_reg      <= '0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_emit;
            if (cmd.write_a)
            begin
                if (it_func_reg == FUNC_ENDPOINTS)
                begin
                    hole_cnt_reg <= '0;
                    ovf_reg      <= 1'b0;
                end
                else if (!store_ok)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.write_b && (it_func_reg == FUNC_WORMHOLE) && store_ok)
                hole_cnt_reg <= hole_cnt_reg + HCW'(1);
            if (cmd.res_emit)
            begin
                hole_cnt_reg <= '0;
                ovf_reg      <= 1'b0;
            end
            if (cmd.init)
            begin
                // Only the start node holds a distance when the search opens.
                valid_reg    <= N'(1);
                pend_reg     <= '0;
                used_reg     <= CNTW'({hole_cnt_reg, 1'b0}) + CNTW'(2);
            end
            if (cmd.latch_first || cmd.next_pass)
            begin
                iss_reg    <= '0;
                found_reg  <= 1'b0;
                p1_vld_reg <= 1'b0;
                p2_vld_reg <= 1'b0;
            end
            if (cmd.pass_run)
            begin
                iss_reg    <= iss_reg + CNTW'(issue);
                p1_vld_reg <= issue;
                p2_vld_reg <= p1_vld_reg;
                if (upd)
                    valid_reg[p2_idx_reg] <= 1'b1;
                if (p2_vld_reg)
                    pend_reg[p2_idx_reg] <= pend_fin && !first;
                if (first)
                    found_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            it_func_reg <= func;
            it_ax_reg   <= ax;
            it_ay_reg   <= ay;
            it_bx_reg   <= bx;
            it_by_reg   <= by;
            it_toll_reg <= toll;
            it_last_reg <= last;
        end
        if (cmd.latch_first)
        begin
            u_idx_reg  <= '0;
            u_x_reg    <= rd_x;
            u_y_reg    <= rd_y;
            u_toll_reg <= rd_toll;
            u_best_reg <= '0;
        end
        if (cmd.next_pass)
        begin
            u_idx_reg  <= nu_idx_reg;
            u_x_reg    <= nu_x_reg;
            u_y_reg    <= nu_y_reg;
            u_toll_reg <= nu_toll_reg;
            u_best_reg <= nu_best_reg;
        end
        if (cmd.pass_run)
        begin
            p1_idx_reg  <= iss_reg[IDXW-1:0];
            p2_idx_reg  <= p1_idx_reg;
            p2_edge_reg <= edge_a;
            p2_best_reg <= best_a;
            p2_x_reg    <= rd_x;
            p2_y_reg    <= rd_y;
            p2_toll_reg <= rd_toll;
        end
        if (cmd.pass_run && first)
        begin
            nu_idx_reg  <= p2_idx_reg;
            nu_x_reg    <= p2_x_reg;
            nu_y_reg    <= p2_y_reg;
            nu_toll_reg <= p2_toll_reg;
            nu_best_reg <= upd ? cand : p2_best_reg;
        end
        if (cmd.res_emit)
        begin
            min_cost_reg <= sat_cost;
            too_many_reg <= ovf_reg;
        end
    end

    assign stat.item_last = it_last_reg;
    assign stat.pass_done = !issue && !p1_vld_reg && !p2_vld_reg;
    assign stat.found     = found_reg;

    assign done     = done_reg;
    assign min_cost = min_cost_reg;
    assign too_many = too_many_reg;

endmodule

`default_nettype wire

>>> rtl/core/wms_checker.sv
// Port-level checks for the wormhole shortest-path block, bound to the top level.
// Sees only the handshake ports; no package dependency.
`default_nettype none

module wms_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A word taken while idle always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A result is shown only once the block is idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Each result is a single-cycle strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A result always follows a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding search");

endmodule

bind wormhole_manhattan_shortest_path wms_checker u_wms_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
